// ===== design/fltc_pkg.sv =====
package fltc_pkg;

	localparam int SCREEN_W_DEF = 640;
	localparam int SCREEN_H_DEF = 480;

	localparam int ROW_W = 9;
	localparam int COL_W = 10;
	localparam int POS_W = 24;
	localparam int VEC_W = 18;
	localparam int TEX_W = 11;
	localparam int TEXEL_W = 10;
	localparam int KIND_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int ACC_W = 40;
	localparam int STEP_W = 32;
	localparam int FRAC_W = 20;
	localparam int TEX_MAX = 1024;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [KIND_W-1:0] KIND_CEILING = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNTOUCHED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POS_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POS_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_COLS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_ROWS = 3'd7;

	localparam logic signed [VEC_W-1:0] DIR_X_RST = 18'sd65536;
	localparam logic signed [VEC_W-1:0] PLANE_Y_RST = 18'sd43254;
	localparam logic [TEX_W-1:0] TEX_SIZE_RST = 11'd64;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0]  pixel_kind;
		logic [TEXEL_W-1:0] texel_x;
		logic [TEXEL_W-1:0] texel_y;
	} res_t;

	typedef struct packed {
		logic [POS_W-1:0]        pos_x;
		logic [POS_W-1:0]        pos_y;
		logic signed [VEC_W-1:0] dir_x;
		logic signed [VEC_W-1:0] dir_y;
		logic signed [VEC_W-1:0] plane_x;
		logic signed [VEC_W-1:0] plane_y;
		logic [TEX_W-1:0]        tex_cols;
		logic [TEX_W-1:0]        tex_rows;
	} cfg_t;

	// classified pixel waiting for the back end
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              texel_en;
		logic              setup;
		logic [ROW_W-1:0]  p;
	} cmd_t;

endpackage

// ===== design/floor_texture_coordinate_caster.sv =====
// Floor casting pixel classifier.
// Requests on in_data (row, col) arrive in raster order over in_valid/in_ready;
// each gives exactly one result on out_data (pixel_kind, texel_x, texel_y) over
// out_valid/out_ready. Registers are written through cfg_we/cfg_index/cfg_data;
// the user writes them only while no request is in flight; the block does not enforce it.
// Each request passes through the queue, and its result is registered in the
// output register; ceiling, untouched and mid-row floor pixels stream at one per
// cycle while out_ready stays high. Column 0 of a floor row runs the row setup
// first: four divisions, for step x, step y, world x and world y in turn, on one
// shared bit-serial divider whose numerator is NUM_W = clog2(SCREEN_H/2 + 1) + 22
// bits wide.
// A four-entry queue sits between the classifier and the texel stage, so
// requests keep being taken while the divider runs or out_ready is low,
// until the queue fills; in_ready drops when it is full.
// When the receiver stalls, the result holds in the output register.
// Reset clears the queue, the world position and step state and loads the
// register reset values; no clearing pass is needed.
module floor_texture_coordinate_caster #(
	parameter int SCREEN_W = fltc_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = fltc_pkg::SCREEN_H_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fltc_pkg::req_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fltc_pkg::res_t                  out_data,
	input  logic                            cfg_we,
	input  logic [fltc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fltc_pkg::CFG_DATA_W-1:0] cfg_data
);

	fltc_pkg::cfg_t cfg_q;
	fltc_pkg::cmd_t cmd;
	fltc_pkg::cmd_t head;
	logic           full;
	logic           head_valid;
	logic           pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x <= '0;
			cfg_q.pos_y <= '0;
			cfg_q.dir_x <= fltc_pkg::DIR_X_RST;
			cfg_q.dir_y <= '0;
			cfg_q.plane_x <= '0;
			cfg_q.plane_y <= fltc_pkg::PLANE_Y_RST;
			cfg_q.tex_cols <= fltc_pkg::TEX_SIZE_RST;
			cfg_q.tex_rows <= fltc_pkg::TEX_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fltc_pkg::REG_POS_X:    cfg_q.pos_x <= cfg_data[fltc_pkg::POS_W-1:0];
				fltc_pkg::REG_POS_Y:    cfg_q.pos_y <= cfg_data[fltc_pkg::POS_W-1:0];
				fltc_pkg::REG_DIR_X:    cfg_q.dir_x <= cfg_data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_DIR_Y:    cfg_q.dir_y <= cfg_data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_PLANE_X:  cfg_q.plane_x <= cfg_data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_PLANE_Y:  cfg_q.plane_y <= cfg_data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_TEX_COLS: cfg_q.tex_cols <= cfg_data[fltc_pkg::TEX_W-1:0];
				fltc_pkg::REG_TEX_ROWS: cfg_q.tex_rows <= cfg_data[fltc_pkg::TEX_W-1:0];
				default:                ;
			endcase
		end
	end

	fltc_front #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_front (
		.req     (in_data),
		.tex_cols(cfg_q.tex_cols),
		.cmd     (cmd)
	);

	assign in_ready = !full;

	fltc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !full),
		.push_data (cmd),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	fltc_back #(
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== design/fltc_front.sv =====
module fltc_front #(
	parameter int SCREEN_W = fltc_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = fltc_pkg::SCREEN_H_DEF
) (
	input  fltc_pkg::req_t                  req,
	input  logic [fltc_pkg::TEX_W-1:0]      tex_cols,
	output fltc_pkg::cmd_t                  cmd
);

	localparam int H2 = SCREEN_H / 2;

	logic [fltc_pkg::ROW_W-1:0] p_raw;

	always_comb begin
		cmd = '0;
		cmd.kind = fltc_pkg::KIND_UNTOUCHED;
		// offset below the horizon, forced odd so even rows repeat the one above
		p_raw = req.row - fltc_pkg::ROW_W'(H2);
		cmd.p = p_raw[0] ? p_raw : p_raw - 1'b1;
		if (32'(req.row) >= 32'(SCREEN_H) || 32'(req.col) >= 32'(SCREEN_W)) begin
			cmd.kind = fltc_pkg::KIND_UNTOUCHED;
		end else if (32'(req.row) < 32'(H2)) begin
			cmd.kind = fltc_pkg::KIND_CEILING;
		end else if (32'(req.row) == 32'(H2) || tex_cols == '0) begin
			cmd.kind = fltc_pkg::KIND_UNTOUCHED;
		end else begin
			cmd.kind = fltc_pkg::KIND_FLOOR;
			cmd.texel_en = 1'b1;
			cmd.setup = (req.col == '0);
		end
	end

endmodule

// ===== design/fltc_queue.sv =====
module fltc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fltc_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output fltc_pkg::cmd_t head
);

	localparam int PTR_W = $clog2(fltc_pkg::QUEUE_DEPTH);

	fltc_pkg::cmd_t   mem_q [fltc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

	assign full = (count_q == (PTR_W+1)'(fltc_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

endmodule

// ===== design/fltc_div.sv =====
module fltc_div #(
	parameter int NUM_W = 30,
	parameter int DEN_W = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num_mag,
	input  logic                       neg,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic [fltc_pkg::ACC_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0]           rem_q;
	logic [DEN_W-1:0]           den_q;
	logic [NUM_W-1:0]           quo_q;
	logic                       neg_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [DEN_W:0]             shifted;
	logic [DEN_W:0]             diff;
	logic                       ge;
	logic [fltc_pkg::ACC_W-1:0] quo_ext;

	// restoring division, one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff = shifted - {1'b0, den_q};
		ge = !diff[DEN_W];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num_mag;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// floor on negative numerators: -q, one further down if a remainder is left
	assign quo_ext = {{(fltc_pkg::ACC_W - NUM_W){1'b0}}, quo_q};
	assign quot = neg_q ? (~quo_ext + fltc_pkg::ACC_W'(rem_q == '0)) : quo_ext;
	assign done = done_q;

endmodule

// ===== design/fltc_back.sv =====
module fltc_back #(
	parameter int SCREEN_W = fltc_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H = fltc_pkg::SCREEN_H_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fltc_pkg::cfg_t cfg,
	input  logic           head_valid,
	input  fltc_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output fltc_pkg::res_t out_data
);

	localparam int H2 = SCREEN_H / 2;
	localparam int H2_W = $clog2(H2 + 1);
	localparam int NUM_W = H2_W + 22;
	localparam int DEN_W = fltc_pkg::ROW_W + $clog2(SCREEN_W + 1);
	localparam int ACC_W = fltc_pkg::ACC_W;
	localparam int STEP_W = fltc_pkg::STEP_W;
	localparam int OPER_W = fltc_pkg::VEC_W + 1;
	localparam logic signed [NUM_W:0] H2_S = (NUM_W+1)'(H2);

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;

	localparam logic [1:0] DIV_STEP_X = 2'd0;
	localparam logic [1:0] DIV_STEP_Y = 2'd1;
	localparam logic [1:0] DIV_ACC_X = 2'd2;
	localparam logic [1:0] DIV_ACC_Y = 2'd3;

	logic [1:0]               state_q;
	logic [1:0]               idx_q;
	logic                     setup_done_q;
	logic [ACC_W-1:0]         acc_x_q;
	logic [ACC_W-1:0]         acc_y_q;
	logic [STEP_W-1:0]        step_x_q;
	logic [STEP_W-1:0]        step_y_q;
	logic                     out_valid_q;
	fltc_pkg::res_t           out_q;
	logic                     can_emit;
	logic                     go_setup;
	logic signed [OPER_W-1:0] oper;
	logic signed [NUM_W:0]    prod;
	logic signed [NUM_W:0]    num_s;
	logic [NUM_W-1:0]         num_mag;
	logic                     num_neg;
	logic [DEN_W-1:0]         den;
	logic                     div_done;
	logic [ACC_W-1:0]         div_quot;

	// texel = (pos*size >> 20) mod size, which is the fraction times size
	function automatic logic [fltc_pkg::TEXEL_W-1:0] texel_of(
		input logic [fltc_pkg::ACC_W-1:0] acc,
		input logic [fltc_pkg::TEX_W-1:0] size
	);
		logic [fltc_pkg::TEX_W-1:0]                   sz;
		logic [fltc_pkg::FRAC_W-1:0]                  frac;
		logic [fltc_pkg::FRAC_W+fltc_pkg::TEX_W-1:0]  mul;
		logic [fltc_pkg::TEX_W-1:0]                   r;
		logic [fltc_pkg::TEX_W-1:0]                   res;
		sz = (size > fltc_pkg::TEX_W'(fltc_pkg::TEX_MAX)) ?
			fltc_pkg::TEX_W'(fltc_pkg::TEX_MAX) : size;
		frac = acc[fltc_pkg::ACC_W-1] ?
			fltc_pkg::FRAC_W'(-acc[fltc_pkg::FRAC_W-1:0]) : acc[fltc_pkg::FRAC_W-1:0];
		mul = (fltc_pkg::FRAC_W+fltc_pkg::TEX_W)'(frac) *
			(fltc_pkg::FRAC_W+fltc_pkg::TEX_W)'(sz);
		r = mul[fltc_pkg::FRAC_W+fltc_pkg::TEX_W-1:fltc_pkg::FRAC_W];
		res = (acc[fltc_pkg::ACC_W-1] && r != '0) ? sz - r : r;
		return res[fltc_pkg::TEXEL_W-1:0];
	endfunction

	assign can_emit = (state_q == ST_RUN) && head_valid && (!head.setup || setup_done_q) &&
		(!out_valid_q || out_ready);
	assign go_setup = (state_q == ST_RUN) && head_valid && head.setup && !setup_done_q;
	assign pop = can_emit;

	// numerator and divisor of the division selected by idx_q
	always_comb begin
		unique case (idx_q)
			DIV_STEP_X: oper = OPER_W'(cfg.plane_x);
			DIV_STEP_Y: oper = OPER_W'(cfg.plane_y);
			DIV_ACC_X:  oper = OPER_W'(cfg.dir_x) - OPER_W'(cfg.plane_x);
			DIV_ACC_Y:  oper = OPER_W'(cfg.dir_y) - OPER_W'(cfg.plane_y);
			default:    oper = '0;
		endcase
		prod = H2_S * (NUM_W+1)'(oper);
		num_s = idx_q[1] ? (prod <<< 4) : (prod <<< 5);
		num_neg = num_s[NUM_W];
		num_mag = num_neg ? NUM_W'(-num_s) : num_s[NUM_W-1:0];
		den = idx_q[1] ? DEN_W'(head.p) : DEN_W'(head.p) * DEN_W'(SCREEN_W);
	end

	fltc_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.num_mag(num_mag),
		.neg    (num_neg),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			idx_q <= DIV_STEP_X;
			setup_done_q <= 1'b0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			step_x_q <= '0;
			step_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_emit) begin
				out_valid_q <= 1'b1;
				setup_done_q <= 1'b0;
				if (head.texel_en) begin
					acc_x_q <= acc_x_q + {{(ACC_W-STEP_W){step_x_q[STEP_W-1]}}, step_x_q};
					acc_y_q <= acc_y_q + {{(ACC_W-STEP_W){step_y_q[STEP_W-1]}}, step_y_q};
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (go_setup) begin
						idx_q <= DIV_STEP_X;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						unique case (idx_q)
							DIV_STEP_X: step_x_q <= div_quot[STEP_W-1:0];
							DIV_STEP_Y: step_y_q <= div_quot[STEP_W-1:0];
							DIV_ACC_X:  acc_x_q <= ACC_W'({cfg.pos_x, 4'b0}) + div_quot;
							DIV_ACC_Y:  acc_y_q <= ACC_W'({cfg.pos_y, 4'b0}) + div_quot;
							default:    ;
						endcase
						if (idx_q == DIV_ACC_Y) begin
							setup_done_q <= 1'b1;
							state_q <= ST_RUN;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (can_emit) begin
			out_q.pixel_kind <= head.kind;
			out_q.texel_x <= head.texel_en ? texel_of(acc_x_q, cfg.tex_cols) : '0;
			out_q.texel_y <= head.texel_en ? texel_of(acc_y_q, cfg.tex_rows) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== design/fltc_checker.sv =====
module fltc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input fltc_pkg::req_t                  in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input fltc_pkg::res_t                  out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed or dropped while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.pixel_kind == fltc_pkg::KIND_CEILING ||
			out_data.pixel_kind == fltc_pkg::KIND_FLOOR ||
			out_data.pixel_kind == fltc_pkg::KIND_UNTOUCHED))
		else $error("illegal pixel kind");

	a_texel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.pixel_kind != fltc_pkg::KIND_FLOOR |->
			out_data.texel_x == '0 && out_data.texel_y == '0)
		else $error("texel set on a non-floor pixel");

endmodule

bind floor_texture_coordinate_caster fltc_checker u_fltc_checker (.*);

// ===== bench/testbench.sv =====
module testbench;

	// Expected texel stream for the floor caster, kept in request order.
	class texel_scoreboard;
		localparam longint HALF_H = fltc_pkg::SCREEN_H_DEF / 2;

		logic [fltc_pkg::POS_W-1:0]        pos_x, pos_y;
		logic signed [fltc_pkg::VEC_W-1:0] dir_x, dir_y, plane_x, plane_y;
		logic [fltc_pkg::TEX_W-1:0]        tex_cols, tex_rows;
		logic [fltc_pkg::ACC_W-1:0]        world_x, world_y;
		logic [fltc_pkg::STEP_W-1:0]       step_x, step_y;
		fltc_pkg::res_t                    expected_pixels[$];
		int                                mismatches;

		function new();
			pos_x = '0;
			pos_y = '0;
			dir_x = fltc_pkg::DIR_X_RST;
			dir_y = '0;
			plane_x = '0;
			plane_y = fltc_pkg::PLANE_Y_RST;
			tex_cols = fltc_pkg::TEX_SIZE_RST;
			tex_rows = fltc_pkg::TEX_SIZE_RST;
			world_x = '0;
			world_y = '0;
			step_x = '0;
			step_y = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [fltc_pkg::CFG_IDX_W-1:0] idx,
				logic [fltc_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				fltc_pkg::REG_POS_X: pos_x = data[fltc_pkg::POS_W-1:0];
				fltc_pkg::REG_POS_Y: pos_y = data[fltc_pkg::POS_W-1:0];
				fltc_pkg::REG_DIR_X: dir_x = data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_DIR_Y: dir_y = data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_PLANE_X: plane_x = data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_PLANE_Y: plane_y = data[fltc_pkg::VEC_W-1:0];
				fltc_pkg::REG_TEX_COLS: tex_cols = data[fltc_pkg::TEX_W-1:0];
				fltc_pkg::REG_TEX_ROWS: tex_rows = data[fltc_pkg::TEX_W-1:0];
				default: ;
			endcase
		endfunction

		function longint floor_div(longint num, longint den);
			longint q;
			q = num / den;
			if (num % den != 0 && num < 0)
				q--;
			return q;
		endfunction

		// trunc(pos * span) mod span, negatives wrapped up
		function logic [fltc_pkg::TEXEL_W-1:0] wrap_texel(logic [fltc_pkg::ACC_W-1:0] acc,
				logic [fltc_pkg::TEX_W-1:0] span_in);
			longint v;
			longint unsigned mag, span, t, r;
			if (span_in == 0)
				return '0;
			span = (span_in > fltc_pkg::TEX_MAX) ? fltc_pkg::TEX_MAX : span_in;
			v = longint'($signed(acc));
			mag = (v < 0) ? -v : v;
			t = (mag * span) >> fltc_pkg::FRAC_W;
			r = t % span;
			if (v < 0 && r != 0)
				r = span - r;
			return r[fltc_pkg::TEXEL_W-1:0];
		endfunction

		function void note_request(fltc_pkg::req_t rq);
			fltc_pkg::res_t px;
			longint         p, xp, yp, xd, yd;
			px = '0;
			px.pixel_kind = fltc_pkg::KIND_UNTOUCHED;
			if (rq.row < fltc_pkg::SCREEN_H_DEF && rq.col < fltc_pkg::SCREEN_W_DEF) begin
				if (rq.row < HALF_H) begin
					px.pixel_kind = fltc_pkg::KIND_CEILING;
				end else if (rq.row != HALF_H && tex_cols != 0) begin
					if (rq.col == 0) begin
						// odd offset: even rows repeat the row above
						p = longint'(rq.row) - HALF_H;
						if (p[0] == 1'b0)
							p--;
						xp = longint'(plane_x);
						yp = longint'(plane_y);
						xd = longint'(dir_x);
						yd = longint'(dir_y);
						step_x = fltc_pkg::STEP_W'(floor_div(HALF_H * xp * 32,
							p * fltc_pkg::SCREEN_W_DEF));
						step_y = fltc_pkg::STEP_W'(floor_div(HALF_H * yp * 32,
							p * fltc_pkg::SCREEN_W_DEF));
						world_x = fltc_pkg::ACC_W'(longint'(pos_x) * 16 +
							floor_div(HALF_H * (xd - xp) * 16, p));
						world_y = fltc_pkg::ACC_W'(longint'(pos_y) * 16 +
							floor_div(HALF_H * (yd - yp) * 16, p));
					end
					px.pixel_kind = fltc_pkg::KIND_FLOOR;
					px.texel_x = wrap_texel(world_x, tex_cols);
					px.texel_y = wrap_texel(world_y, tex_rows);
					world_x = world_x + fltc_pkg::ACC_W'(longint'($signed(step_x)));
					world_y = world_y + fltc_pkg::ACC_W'(longint'($signed(step_y)));
				end
			end
			expected_pixels.push_back(px);
		endfunction

		function void check_result(fltc_pkg::res_t got);
			fltc_pkg::res_t want;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request pending: kind %0d tx %0d ty %0d",
						$time, got.pixel_kind, got.texel_x, got.texel_y);
				return;
			end
			want = expected_pixels.pop_front();
			if (got.pixel_kind !== want.pixel_kind || got.texel_x !== want.texel_x ||
					got.texel_y !== want.texel_y) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: exp kind %0d tx %0d ty %0d, got kind %0d tx %0d ty %0d",
						$time, want.pixel_kind, want.texel_x, want.texel_y,
						got.pixel_kind, got.texel_x, got.texel_y);
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_ready;
	fltc_pkg::req_t                  in_data = '0;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	fltc_pkg::res_t                  out_data;
	logic                            cfg_we = 1'b0;
	logic [fltc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [fltc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [fltc_pkg::CFG_DATA_W-1:0] view_regs [8];
	int                              send_idle_pct = 24;
	int                              recv_idle_pct = 66;
	texel_scoreboard                 sb;

	floor_texture_coordinate_caster dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	task automatic send_pixel(input logic [fltc_pkg::ROW_W-1:0] row,
			input logic [fltc_pkg::COL_W-1:0] col);
		fltc_pkg::req_t rq;
		rq.row = row;
		rq.col = col;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= rq;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold off the sender until every pending pixel has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic apply_view();
		for (int i = 0; i <= fltc_pkg::REG_TEX_ROWS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= fltc_pkg::CFG_IDX_W'(i);
			cfg_data <= view_regs[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [fltc_pkg::CFG_DATA_W-1:0] random_tex_size(input bit allow_zero);
		case ($urandom_range(0, 5))
			0: return allow_zero ? '0 : fltc_pkg::CFG_DATA_W'($urandom_range(1, 16));
			1: return fltc_pkg::CFG_DATA_W'(1) << $urandom_range(0, 10);
			2: return fltc_pkg::CFG_DATA_W'($urandom_range(1, fltc_pkg::TEX_MAX));
			3: return fltc_pkg::CFG_DATA_W'($urandom_range(fltc_pkg::TEX_MAX + 1, 2047));
			4: return fltc_pkg::CFG_DATA_W'($urandom);
			default: return fltc_pkg::CFG_DATA_W'(64);
		endcase
	endfunction

	task automatic random_view();
		view_regs[fltc_pkg::REG_POS_X] = fltc_pkg::CFG_DATA_W'($urandom);
		view_regs[fltc_pkg::REG_POS_Y] = fltc_pkg::CFG_DATA_W'($urandom);
		// unit-scale vectors or the full register range, half the time each
		view_regs[fltc_pkg::REG_DIR_X] = ($urandom_range(0, 1)) ?
			fltc_pkg::CFG_DATA_W'($urandom) :
			fltc_pkg::CFG_DATA_W'(int'($urandom_range(0, 131072)) - 65536);
		view_regs[fltc_pkg::REG_DIR_Y] = ($urandom_range(0, 1)) ?
			fltc_pkg::CFG_DATA_W'($urandom) :
			fltc_pkg::CFG_DATA_W'(int'($urandom_range(0, 131072)) - 65536);
		view_regs[fltc_pkg::REG_PLANE_X] = ($urandom_range(0, 1)) ?
			fltc_pkg::CFG_DATA_W'($urandom) :
			fltc_pkg::CFG_DATA_W'(int'($urandom_range(0, 87000)) - 43500);
		view_regs[fltc_pkg::REG_PLANE_Y] = ($urandom_range(0, 1)) ?
			fltc_pkg::CFG_DATA_W'($urandom) :
			fltc_pkg::CFG_DATA_W'(int'($urandom_range(0, 87000)) - 43500);
		view_regs[fltc_pkg::REG_TEX_COLS] = random_tex_size($urandom_range(0, 3) == 0);
		view_regs[fltc_pkg::REG_TEX_ROWS] = random_tex_size(1'b1);
	endtask

	// raster runs, mostly starting at column 0, mixed with stray pixels
	task automatic random_stream(input int count);
		int                          sent;
		int                          run_len;
		int                          c;
		logic [fltc_pkg::ROW_W-1:0]  r;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 8) begin
				send_pixel(fltc_pkg::ROW_W'($urandom), fltc_pkg::COL_W'($urandom));
				sent++;
			end else begin
				r = ($urandom_range(0, 99) < 80) ?
					fltc_pkg::ROW_W'($urandom_range(241, 479)) :
					fltc_pkg::ROW_W'($urandom_range(0, 240));
				c = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 639);
				run_len = ($urandom_range(0, 99) < 2) ? fltc_pkg::SCREEN_W_DEF :
					$urandom_range(1, 24);
				for (int j = 0; j < run_len && c + j < 1024 && sent < count; j++) begin
					send_pixel(r, fltc_pkg::COL_W'(c + j));
					sent++;
				end
			end
		end
	endtask

	initial begin
		#(20 * 2000000);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: ceiling, horizon, floor edges, out-of-screen pixels
		send_pixel(0, 0);
		send_pixel(239, 639);
		send_pixel(240, 0);
		send_pixel(240, 639);
		send_pixel(241, 0);
		send_pixel(241, 1);
		send_pixel(241, 639);
		send_pixel(242, 0);
		send_pixel(242, 1);
		send_pixel(479, 0);
		send_pixel(479, 639);
		send_pixel(480, 0);
		send_pixel(511, 1023);
		send_pixel(300, 640);
		send_pixel(300, 7);
		send_pixel(0, 1023);
		drain();

		// register extremes, oversized width, zero height
		view_regs[fltc_pkg::REG_POS_X] = '1;
		view_regs[fltc_pkg::REG_POS_Y] = '0;
		view_regs[fltc_pkg::REG_DIR_X] = fltc_pkg::CFG_DATA_W'(-131072);
		view_regs[fltc_pkg::REG_DIR_Y] = fltc_pkg::CFG_DATA_W'(131071);
		view_regs[fltc_pkg::REG_PLANE_X] = fltc_pkg::CFG_DATA_W'(131071);
		view_regs[fltc_pkg::REG_PLANE_Y] = fltc_pkg::CFG_DATA_W'(-131072);
		view_regs[fltc_pkg::REG_TEX_COLS] = fltc_pkg::CFG_DATA_W'(2047);
		view_regs[fltc_pkg::REG_TEX_ROWS] = '0;
		apply_view();
		send_pixel(241, 0);
		send_pixel(241, 1);
		send_pixel(479, 0);
		send_pixel(479, 639);
		drain();

		// no floor texture
		view_regs[fltc_pkg::REG_POS_X] = '0;
		view_regs[fltc_pkg::REG_DIR_X] = '0;
		view_regs[fltc_pkg::REG_DIR_Y] = '0;
		view_regs[fltc_pkg::REG_PLANE_X] = '0;
		view_regs[fltc_pkg::REG_PLANE_Y] = '0;
		view_regs[fltc_pkg::REG_TEX_COLS] = '0;
		view_regs[fltc_pkg::REG_TEX_ROWS] = fltc_pkg::CFG_DATA_W'(fltc_pkg::TEX_MAX);
		apply_view();
		send_pixel(300, 0);
		send_pixel(300, 1);
		send_pixel(100, 5);
		send_pixel(240, 0);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 66 : 0;
			recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 24 : 0;
			for (int k = 0; k < 4; k++) begin
				random_view();
				apply_view();
				random_stream(106);
				drain();
			end
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
